// ===== src/i2cram_pkg.sv =====
package i2cram_pkg;

  // Longest read run that one command performs; larger read counts are clamped to it.
  localparam int unsigned MAX_READ_BYTES = 16;

  // Configuration register indexes and reset values.
  localparam logic [0:0] CFG_DEV_ADDR    = 1'b0;
  localparam logic [0:0] CFG_PHASE_TICKS = 1'b1;
  localparam logic [6:0] DEV_ADDR_RESET    = 7'd41;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd200;

  // Command kinds carried with each input word.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Completion status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NACK_ADDR  = 3'd1;
  localparam logic [2:0] ST_NACK_REG   = 3'd2;
  localparam logic [2:0] ST_NACK_DATA  = 3'd3;
  localparam logic [2:0] ST_NACK_RADDR = 3'd4;

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START1,
    PH_TX_ADDR_W,
    PH_TX_REG,
    PH_TX_DATA,
    PH_START2,
    PH_TX_ADDR_R,
    PH_RX,
    PH_STOP
  } phase_t;

  // One input word, unpacked.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [4:0] read_count;
    logic       sda_in;
  } cmd_t;

  // One result word, unpacked.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       done_res;
    logic [2:0] status;
  } res_t;

endpackage

// ===== src/i2cram_seq.sv =====
module i2cram_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  i2cram_pkg::cmd_t   cmd,
  input  logic [6:0]         device_address,
  input  logic [15:0]        phase_ticks,
  output i2cram_pkg::res_t   res
);
  import i2cram_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  sub_step, sub_step_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [4:0]  bytes_left, bytes_left_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  held_register, held_register_next;
  logic [7:0]  held_write_value, held_write_value_next;
  logic        is_read_command, is_read_command_next;
  logic [2:0]  error_code, error_code_next;

  logic [15:0] limit;
  logic        is_tx;

  assign limit = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  // Control state of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      sub_step        <= '0;
      bit_index       <= '0;
      shift_byte      <= '0;
      bytes_left      <= '0;
      tick_count      <= '0;
      is_read_command <= 1'b0;
      error_code      <= ST_OK;
    end else if (step) begin
      phase           <= phase_next;
      sub_step        <= sub_step_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      bytes_left      <= bytes_left_next;
      tick_count      <= tick_count_next;
      is_read_command <= is_read_command_next;
      error_code      <= error_code_next;
    end
  end

  // Command operands are held for the whole transaction.
  always_ff @(posedge clk) begin
    if (step) begin
      held_register    <= held_register_next;
      held_write_value <= held_write_value_next;
    end
  end

  // One tick of the sequencer: command capture, line levels, then phase advance.
  always_comb begin
    phase_next            = phase;
    sub_step_next         = sub_step;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    bytes_left_next       = bytes_left;
    tick_count_next       = tick_count;
    held_register_next    = held_register;
    held_write_value_next = held_write_value;
    is_read_command_next  = is_read_command;
    error_code_next       = error_code;
    res                   = '0;
    res.scl_level         = 1'b1;
    res.sda_level         = 1'b1;

    // An idle sequencer takes a command on the tick it arrives.
    if (phase == PH_IDLE && (cmd.kind == KIND_WRITE || cmd.kind == KIND_READ)) begin
      held_register_next    = cmd.reg_addr;
      held_write_value_next = cmd.write_data;
      is_read_command_next  = (cmd.kind == KIND_READ);
      bytes_left_next       = (cmd.read_count > 5'(MAX_READ_BYTES)) ?
                              5'(MAX_READ_BYTES) : cmd.read_count;
      error_code_next       = ST_OK;
      phase_next            = PH_START1;
      sub_step_next         = '0;
      bit_index_next        = '0;
      shift_byte_next       = '0;
      tick_count_next       = '0;
    end

    is_tx = (phase_next == PH_TX_ADDR_W) || (phase_next == PH_TX_REG) ||
            (phase_next == PH_TX_DATA) || (phase_next == PH_TX_ADDR_R);

    if (phase_next != PH_IDLE) begin
      // Line levels come from the state at the start of the tick.
      unique case (phase_next)
        PH_START1, PH_START2: begin
          res.scl_level = (sub_step_next < 2'd2);
          res.sda_level = (sub_step_next == 2'd0);
        end
        PH_STOP: begin
          res.scl_level = (sub_step_next != 2'd0);
          res.sda_level = (sub_step_next == 2'd2);
        end
        PH_TX_ADDR_W, PH_TX_REG, PH_TX_DATA, PH_TX_ADDR_R: begin
          res.scl_level = (sub_step_next == 2'd1);
          res.sda_level = (bit_index_next < 4'd8) ? shift_byte_next[7] : 1'b1;
        end
        PH_RX: begin
          if (bit_index_next < 4'd8) begin
            res.scl_level = (sub_step_next == 2'd0);
            res.sda_level = 1'b1;
          end else begin
            res.scl_level = (sub_step_next == 2'd1);
            res.sda_level = !(bytes_left_next > 5'd1);
          end
        end
        default: begin
          res.scl_level = 1'b1;
          res.sda_level = 1'b1;
        end
      endcase

      tick_count_next = tick_count_next + 16'd1;

      // Phase step at the end of each phase period.
      if (tick_count_next >= limit) begin
        tick_count_next = '0;
        if (phase_next == PH_START1 || phase_next == PH_START2) begin
          if (sub_step_next < 2'd2) begin
            sub_step_next = sub_step_next + 2'd1;
          end else begin
            shift_byte_next = (phase_next == PH_START1) ? {device_address, 1'b0}
                                                        : {device_address, 1'b1};
            phase_next      = (phase_next == PH_START1) ? PH_TX_ADDR_W : PH_TX_ADDR_R;
            bit_index_next  = '0;
            sub_step_next   = '0;
          end
        end else if (phase_next == PH_STOP) begin
          if (sub_step_next < 2'd2) begin
            sub_step_next = sub_step_next + 2'd1;
          end else begin
            phase_next    = PH_IDLE;
            sub_step_next = '0;
            res.done_res  = 1'b1;
            res.status    = error_code_next;
          end
        end else if (is_tx) begin
          if (bit_index_next < 4'd8) begin
            if (sub_step_next < 2'd2) begin
              sub_step_next = sub_step_next + 2'd1;
            end else begin
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
              bit_index_next  = bit_index_next + 4'd1;
              sub_step_next   = '0;
            end
          end else if (sub_step_next == 2'd0) begin
            sub_step_next = 2'd1;
          end else if (cmd.sda_in) begin
            // No acknowledge: stop with the code of the byte that failed.
            unique case (phase_next)
              PH_TX_ADDR_W: error_code_next = ST_NACK_ADDR;
              PH_TX_REG:    error_code_next = ST_NACK_REG;
              PH_TX_DATA:   error_code_next = ST_NACK_DATA;
              default:      error_code_next = ST_NACK_RADDR;
            endcase
            phase_next     = PH_STOP;
            sub_step_next  = '0;
            bit_index_next = '0;
          end else if (phase_next == PH_TX_ADDR_W) begin
            phase_next      = PH_TX_REG;
            shift_byte_next = held_register_next;
            bit_index_next  = '0;
            sub_step_next   = '0;
          end else if (phase_next == PH_TX_REG) begin
            if (is_read_command_next) begin
              phase_next     = PH_START2;
              sub_step_next  = '0;
              bit_index_next = '0;
            end else begin
              phase_next      = PH_TX_DATA;
              shift_byte_next = held_write_value_next;
              bit_index_next  = '0;
              sub_step_next   = '0;
            end
          end else if (phase_next == PH_TX_DATA || bytes_left_next == 5'd0) begin
            error_code_next = ST_OK;
            phase_next      = PH_STOP;
            sub_step_next   = '0;
            bit_index_next  = '0;
          end else begin
            phase_next      = PH_RX;
            shift_byte_next = '0;
            bit_index_next  = '0;
            sub_step_next   = '0;
          end
        end else begin
          // Receive: sample on the high half, then the master's ack bit.
          if (bit_index_next < 4'd8) begin
            if (sub_step_next == 2'd0) begin
              shift_byte_next = {shift_byte_next[6:0], cmd.sda_in};
              sub_step_next   = 2'd1;
            end else begin
              bit_index_next = bit_index_next + 4'd1;
              sub_step_next  = '0;
            end
          end else if (sub_step_next == 2'd0) begin
            sub_step_next = 2'd1;
          end else begin
            res.byte_valid  = 1'b1;
            res.read_byte   = shift_byte_next;
            res.last_byte   = (bytes_left_next <= 5'd1);
            bytes_left_next = (bytes_left_next != 5'd0) ? bytes_left_next - 5'd1 : 5'd0;
            if (bytes_left_next == 5'd0) begin
              error_code_next = ST_OK;
              phase_next      = PH_STOP;
              bit_index_next  = '0;
            end else begin
              phase_next      = PH_RX;
              shift_byte_next = '0;
              bit_index_next  = '0;
            end
            sub_step_next = '0;
          end
        end
      end
    end

    res.busy_res = (phase_next != PH_IDLE);
  end

endmodule

// ===== src/i2cram_out.sv =====
module i2cram_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  i2cram_pkg::res_t res,
  input  logic             m_tready,
  output logic             m_tvalid,
  output logic             room,
  output i2cram_pkg::res_t held
);
  import i2cram_pkg::*;

  // The register can take a new word when empty or being drained this cycle.
  assign room = !m_tvalid || m_tready;

  // Valid flag of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// ===== src/i2c_register_access_master_core.sv =====
// I2C master for 8-bit register access on open-drain lines. Every input word is one
// bus tick and yields exactly one result word with the SCL/SDA levels to drive
// (1 releases the line), busy, any received byte with its last flag, and a done
// pulse with status (0 ok, 1 nack address, 2 nack register, 3 nack data, 4 nack
// read address). A write or read command in tuser is taken only while idle; each
// bus phase lasts phase_ticks words (0 acts as 1), so SCL runs at one bit per three
// or two phases. A new word is taken every cycle; the one result register after it
// stalls input only while a result waits and m_tready is low. Configuration
// registers must be written by the user through cfg_we/cfg_index/cfg_data only
// while no transaction is running; the block itself does not enforce it.
module i2c_register_access_master_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // reg_addr[7:0], write_data[15:8], read_count[20:16],
                                 // sda_in[21], zero fill [23:22]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_level[0], sda_level[1], busy_res[2], byte_valid[3],
                                 // read_byte[11:4], done_res[12], status[15:13]
  output logic        m_tlast,   // last_byte
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import i2cram_pkg::*;

  logic [6:0]  device_address;
  logic [15:0] phase_ticks;
  logic        step;
  cmd_t        cmd;
  res_t        res;
  res_t        held;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEV_ADDR_RESET;
      phase_ticks    <= PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:    device_address <= cfg_data[6:0];
        CFG_PHASE_TICKS: phase_ticks    <= cfg_data;
        default:         phase_ticks    <= phase_ticks;
      endcase
    end
  end

  // Unpack the input word.
  assign cmd.kind       = s_tuser;
  assign cmd.reg_addr   = s_tdata[7:0];
  assign cmd.write_data = s_tdata[15:8];
  assign cmd.read_count = s_tdata[20:16];
  assign cmd.sda_in     = s_tdata[21];

  assign step = s_tvalid && s_tready;

  i2cram_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .cmd            (cmd),
    .device_address (device_address),
    .phase_ticks    (phase_ticks),
    .res            (res)
  );

  i2cram_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .room     (s_tready),
    .held     (held)
  );

  // Pack the result word.
  assign m_tdata = {held.status, held.done_res, held.read_byte, held.byte_valid,
                    held.busy_res, held.sda_level, held.scl_level};
  assign m_tlast = held.last_byte;

endmodule

// ===== verif/tb_i2c_register_access_master_core.sv =====
module tb_i2c_register_access_master_core;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cram_pkg::*;

  // A command kind outside the defined set; the block must treat it as a plain tick.
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam int N_RANDOM    = 100;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 500000;
  localparam int N_ROWS      = 17;

  typedef enum logic [1:0] {ROW_TICK, ROW_CFG, ROW_CMD} row_op_t;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} ready_mode_t;

  // One line of the directed script. A tick row expects the idle word, a command row
  // runs a whole transfer and expects the given status on its done word.
  typedef struct packed {
    row_op_t     op;
    logic [0:0]  cfg_sel;
    logic [15:0] cfg_value;
    logic [1:0]  kind;
    logic [7:0]  reg_addr;
    logic [7:0]  write_data;
    logic [4:0]  read_count;
    logic        sda_in;
    phase_t      refuse;   // acknowledge slot that is left high
    logic        noise;    // offer ignored commands while the transfer runs
    logic [2:0]  want;
  } row_t;

  localparam row_t SCRIPT [N_ROWS] = '{
    '{ROW_TICK, 1'b0, 16'd0, KIND_TICK, 8'h00, 8'h00, 5'd0, 1'b0, PH_IDLE, 1'b0, ST_OK},
    '{ROW_TICK, 1'b0, 16'd0, KIND_UNKNOWN, 8'hFF, 8'hFF, 5'd31, 1'b1, PH_IDLE, 1'b0, ST_OK},
    '{ROW_CFG, CFG_PHASE_TICKS, 16'd0, KIND_TICK, 8'h00, 8'h00, 5'd0, 1'b0, PH_IDLE, 1'b0,
      ST_OK},
    '{ROW_CFG, CFG_DEV_ADDR, 16'd0, KIND_TICK, 8'h00, 8'h00, 5'd0, 1'b0, PH_IDLE, 1'b0, ST_OK},
    '{ROW_CMD, 1'b0, 16'd0, KIND_WRITE, 8'hFF, 8'h00, 5'd31, 1'b1, PH_TX_ADDR_W, 1'b0,
      ST_NACK_ADDR},
    '{ROW_CFG, CFG_PHASE_TICKS, 16'd1, KIND_TICK, 8'h00, 8'h00, 5'd0, 1'b0, PH_IDLE, 1'b0,
      ST_OK},
    '{ROW_CMD, 1'b0, 16'd0, KIND_WRITE, 8'h5A, 8'hA5, 5'd0, 1'b0, PH_TX_REG, 1'b0, ST_NACK_REG},
    '{ROW_CMD, 1'b0, 16'd0, KIND_WRITE, 8'h3C, 8'hC3, 5'd0, 1'b0, PH_TX_DATA, 1'b0,
      ST_NACK_DATA},
    '{ROW_CMD, 1'b0, 16'd0, KIND_READ, 8'h81, 8'h7E, 5'd1, 1'b1, PH_TX_ADDR_R, 1'b0,
      ST_NACK_RADDR},
    '{ROW_CFG, CFG_DEV_ADDR, 16'd127, KIND_TICK, 8'h00, 8'h00, 5'd0, 1'b0, PH_IDLE, 1'b0,
      ST_OK},
    '{ROW_CMD, 1'b0, 16'd0, KIND_READ, 8'h00, 8'h00, 5'd0, 1'b0, PH_IDLE, 1'b0, ST_OK},
    '{ROW_CMD, 1'b0, 16'd0, KIND_READ, 8'hFF, 8'hFF, 5'd31, 1'b1, PH_IDLE, 1'b1, ST_OK},
    '{ROW_CFG, CFG_PHASE_TICKS, 16'd3, KIND_TICK, 8'h00, 8'h00, 5'd0, 1'b0, PH_IDLE, 1'b0,
      ST_OK},
    '{ROW_CMD, 1'b0, 16'd0, KIND_READ, 8'h01, 8'hFF, 5'd1, 1'b0, PH_TX_ADDR_W, 1'b0,
      ST_NACK_ADDR},
    '{ROW_CFG, CFG_PHASE_TICKS, 16'hFFFF, KIND_TICK, 8'h00, 8'h00, 5'd0, 1'b0, PH_IDLE, 1'b0,
      ST_OK},
    '{ROW_TICK, 1'b0, 16'd0, KIND_TICK, 8'hFF, 8'h00, 5'd16, 1'b1, PH_IDLE, 1'b0, ST_OK},
    '{ROW_TICK, 1'b0, 16'd0, KIND_UNKNOWN, 8'h00, 8'hFF, 5'd0, 1'b0, PH_IDLE, 1'b0, ST_OK}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = KIND_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_DEV_ADDR;
  logic [15:0] cfg_data = '0;

  i2c_register_access_master_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // Predicted bus words, oldest first.
  res_t bus_words_due [$];

  int mismatches    = 0;
  int words_checked = 0;
  int items_sent    = 0;
  int burst_left    = 0;
  int hold_reqs     = 0;
  int cycles        = 0;
  int transfers     = 0;
  int reads_run     = 0;
  int error_stops   = 0;
  int bytes_read    = 0;

  // Sequencer mirror and its configuration.
  phase_t      bus_ph    = PH_IDLE;
  logic [1:0]  sub_step  = '0;
  logic [3:0]  bit_idx   = '0;
  logic [7:0]  shreg     = '0;
  logic [4:0]  left      = '0;
  logic [15:0] ticks     = '0;
  logic [7:0]  held_reg  = '0;
  logic [7:0]  held_val  = '0;
  logic        rd_cmd    = 1'b0;
  logic [2:0]  err       = ST_OK;
  logic [6:0]  dev_addr  = DEV_ADDR_RESET;
  logic [15:0] phase_len = PHASE_TICKS_RESET;
  phase_t      refuse_ph = PH_IDLE;

  function automatic void load_byte(phase_t ph, logic [7:0] value);
    bus_ph   = ph;
    shreg    = value;
    bit_idx  = '0;
    sub_step = '0;
  endfunction

  function automatic void stop_bus(logic [2:0] code);
    err      = code;
    bus_ph   = PH_STOP;
    sub_step = '0;
    bit_idx  = '0;
  endfunction

  // Word with both lines released, as seen when idle or on the tick that ends a stop.
  function automatic res_t released_word(logic done, logic [2:0] st);
    res_t r;
    r = '0;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.done_res  = done;
    r.status    = st;
    return r;
  endfunction

  // Advance the sequencer mirror by one tick and return the word it produces.
  function automatic res_t step_bus(cmd_t w);
    res_t        r;
    logic [15:0] lim;
    r   = released_word(1'b0, ST_OK);
    lim = (phase_len == 16'd0) ? 16'd1 : phase_len;

    // A command is taken only while idle.
    if (bus_ph == PH_IDLE && (w.kind == KIND_WRITE || w.kind == KIND_READ)) begin
      held_reg = w.reg_addr;
      held_val = w.write_data;
      rd_cmd   = (w.kind == KIND_READ);
      left     = (w.read_count > 5'(MAX_READ_BYTES)) ? 5'(MAX_READ_BYTES) : w.read_count;
      err      = ST_OK;
      bus_ph   = PH_START1;
      sub_step = '0;
      bit_idx  = '0;
      shreg    = '0;
      ticks    = '0;
    end

    if (bus_ph != PH_IDLE) begin
      // Line levels belong to the phase as it stands before this tick advances it.
      case (bus_ph)
        PH_START1, PH_START2: begin
          r.scl_level = (sub_step < 2'd2);
          r.sda_level = (sub_step == 2'd0);
        end
        PH_STOP: begin
          r.scl_level = (sub_step > 2'd0);
          r.sda_level = (sub_step == 2'd2);
        end
        PH_RX: begin
          if (bit_idx < 4'd8) begin
            r.scl_level = (sub_step == 2'd0);
            r.sda_level = 1'b1;
          end else begin
            r.scl_level = (sub_step == 2'd1);
            r.sda_level = (left > 5'd1) ? 1'b0 : 1'b1;
          end
        end
        default: begin
          r.scl_level = (sub_step == 2'd1);
          r.sda_level = (bit_idx < 4'd8) ? shreg[7] : 1'b1;
        end
      endcase

      ticks = ticks + 16'd1;
      if (ticks >= lim) begin
        ticks = '0;
        case (bus_ph)
          PH_START1, PH_START2: begin
            if (sub_step < 2'd2) sub_step = sub_step + 2'd1;
            else if (bus_ph == PH_START1) load_byte(PH_TX_ADDR_W, {dev_addr, 1'b0});
            else load_byte(PH_TX_ADDR_R, {dev_addr, 1'b1});
          end
          PH_STOP: begin
            if (sub_step < 2'd2) begin
              sub_step = sub_step + 2'd1;
            end else begin
              bus_ph     = PH_IDLE;
              sub_step   = '0;
              r.done_res = 1'b1;
              r.status   = err;
            end
          end
          PH_RX: begin
            if (bit_idx < 4'd8) begin
              if (sub_step == 2'd0) begin
                shreg    = {shreg[6:0], w.sda_in};
                sub_step = 2'd1;
              end else begin
                bit_idx  = bit_idx + 4'd1;
                sub_step = '0;
              end
            end else if (sub_step == 2'd0) begin
              sub_step = 2'd1;
            end else begin
              r.byte_valid = 1'b1;
              r.read_byte  = shreg;
              r.last_byte  = (left <= 5'd1);
              left = (left > 5'd0) ? left - 5'd1 : 5'd0;
              if (left == 5'd0) stop_bus(ST_OK);
              else load_byte(PH_RX, 8'h00);
            end
          end
          default: begin
            // Byte transmit: eight bits of three phases, then a two-phase acknowledge slot.
            if (bit_idx < 4'd8) begin
              if (sub_step < 2'd2) begin
                sub_step = sub_step + 2'd1;
              end else begin
                shreg    = shreg << 1;
                bit_idx  = bit_idx + 4'd1;
                sub_step = '0;
              end
            end else if (sub_step == 2'd0) begin
              sub_step = 2'd1;
            end else if (w.sda_in) begin
              case (bus_ph)
                PH_TX_ADDR_W: stop_bus(ST_NACK_ADDR);
                PH_TX_REG:    stop_bus(ST_NACK_REG);
                PH_TX_DATA:   stop_bus(ST_NACK_DATA);
                default:      stop_bus(ST_NACK_RADDR);
              endcase
            end else begin
              case (bus_ph)
                PH_TX_ADDR_W: load_byte(PH_TX_REG, held_reg);
                PH_TX_REG: begin
                  if (rd_cmd) begin
                    bus_ph   = PH_START2;
                    sub_step = '0;
                    bit_idx  = '0;
                  end else begin
                    load_byte(PH_TX_DATA, held_val);
                  end
                end
                PH_TX_DATA: stop_bus(ST_OK);
                default: begin
                  if (left == 5'd0) stop_bus(ST_OK);
                  else load_byte(PH_RX, 8'h00);
                end
              endcase
            end
          end
        endcase
      end
    end

    r.busy_res = (bus_ph != PH_IDLE);
    return r;
  endfunction

  // Next tick word of a running transfer. The acknowledge slots are answered low unless
  // this transfer is meant to be refused there; everything else is random.
  function automatic cmd_t tick_word(logic noise);
    cmd_t w;
    w.kind       = KIND_TICK;
    w.reg_addr   = 8'($urandom);
    w.write_data = 8'($urandom);
    w.read_count = 5'($urandom);
    w.sda_in     = 1'($urandom);
    if (noise && $urandom_range(0, 7) == 0) w.kind = 2'($urandom_range(1, 3));
    if ((bus_ph inside {PH_TX_ADDR_W, PH_TX_REG, PH_TX_DATA, PH_TX_ADDR_R}) &&
        bit_idx == 4'd8)
      w.sda_in = (bus_ph == refuse_ph);
    return w;
  endfunction

  task automatic report(string what, int got, int want);
    mismatches++;
    if (mismatches <= 50)
      $display("word %0d: %s is %0d, expected %0d", words_checked, what, got, want);
  endtask

  // Offer one word, wait for the handshake, record its prediction, then idle per burst.
  task automatic send_word(cmd_t w, logic typed, res_t typed_res);
    res_t want;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, w.sda_in, w.read_count, w.write_data, w.reg_addr};
    s_tuser  <= w.kind;
    do @(posedge clk); while (!s_tready);
    want = step_bus(w);
    if (typed && !want.busy_res) want = typed_res;
    bus_words_due.push_back(want);
    items_sent++;
    if (want.byte_valid) bytes_read++;
    if (want.done_res && want.status != ST_OK) error_stops++;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic run_transfer(cmd_t c, phase_t refuse, logic noise, logic typed,
                              logic [2:0] want);
    refuse_ph = refuse;
    transfers++;
    if (c.kind == KIND_READ) reads_run++;
    send_word(c, typed, released_word(1'b1, want));
    while (bus_ph != PH_IDLE) send_word(tick_word(noise), typed, released_word(1'b1, want));
  endtask

  // Stop offering and let every predicted word come out, plus a few settling cycles.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (bus_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] sel, logic [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_DEV_ADDR) dev_addr = value[6:0];
    else phase_len = value;
  endtask

  // Stimulus: directed script first, then random transfers.
  initial begin
    row_t        row;
    cmd_t        c;
    phase_t      refuse;
    int          xfer;
    int          first_random;
    int          pick;
    logic [15:0] ticks_cfg;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      row          = SCRIPT[i];
      c.kind       = row.kind;
      c.reg_addr   = row.reg_addr;
      c.write_data = row.write_data;
      c.read_count = row.read_count;
      c.sda_in     = row.sda_in;
      case (row.op)
        ROW_CFG:  write_reg(row.cfg_sel, row.cfg_value);
        ROW_TICK: send_word(c, 1'b1, released_word(1'b0, ST_OK));
        default:  run_transfer(c, row.refuse, row.noise, 1'b1, row.want);
      endcase
    end

    first_random = items_sent;
    xfer = 0;
    while (items_sent - first_random < N_RANDOM) begin
      // Fresh settings every few transfers, mostly short phases to keep transfers quick.
      if (xfer % 3 == 0) begin
        pick = $urandom_range(0, 9);
        ticks_cfg = (pick == 0) ? 16'd0 : (pick < 6) ? 16'd1 : (pick < 8) ? 16'd2 :
                    16'($urandom_range(3, 6));
        write_reg(CFG_PHASE_TICKS, ticks_cfg);
        if ($urandom_range(0, 1) == 0) begin
          pick = $urandom_range(0, 9);
          write_reg(CFG_DEV_ADDR, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd127 :
                    {9'd0, 7'($urandom)});
        end
      end
      // Long receiver hold-off with the sender pushing hard, and one full pause.
      if (xfer == 0) begin
        hold_reqs++;
        burst_left = 200;
      end
      if (xfer == 1) drain_results();

      c.kind       = ($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_READ;
      c.reg_addr   = 8'($urandom);
      c.write_data = 8'($urandom);
      c.sda_in     = 1'($urandom);
      pick         = $urandom_range(0, 19);
      c.read_count = (pick < 16) ? 5'($urandom_range(0, 3)) :
                     (pick < 19) ? 5'($urandom_range(4, 16)) : 5'($urandom_range(17, 31));
      pick = $urandom_range(0, 11);
      refuse = (pick == 0) ? PH_TX_ADDR_W : (pick == 1) ? PH_TX_REG :
               (pick == 2) ? PH_TX_DATA : (pick == 3) ? PH_TX_ADDR_R : PH_IDLE;
      run_transfer(c, refuse, 1'($urandom_range(0, 2) == 0), 1'b0, ST_OK);

      // A few plain ticks between transfers.
      repeat ($urandom_range(0, 2)) begin
        c.kind       = ($urandom_range(0, 3) == 0) ? KIND_UNKNOWN : KIND_TICK;
        c.reg_addr   = 8'($urandom);
        c.write_data = 8'($urandom);
        c.read_count = 5'($urandom);
        c.sda_in     = 1'($urandom);
        send_word(c, 1'b0, released_word(1'b0, ST_OK));
      end
      xfer++;
    end

    s_tvalid <= 1'b0;
    while (bus_words_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Ran %0d bus ticks in %0d transfers (%0d reads, %0d refused), %0d bytes read,",
             items_sent, transfers, reads_run, error_stops, bytes_read);
    $display("under several address and phase-length settings with random stalls.");
    if (mismatches == 0) begin
      $display("i2c_register_access_master_core: match");
    end else begin
      $display("i2c_register_access_master_core: mismatch");
    end
    $finish;
  end

  // Receiver: changes its stall pattern every so often and honors hold-off requests.
  ready_mode_t rdy_mode  = RDY_ALWAYS;
  int          mode_left = 0;
  int          hold_left = 0;
  int          hold_seen = 0;
  logic [1:0]  pat_cnt   = '0;

  always @(posedge clk) begin
    pat_cnt <= pat_cnt + 2'd1;
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_reqs) begin
      hold_seen++;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = ready_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS: m_tready <= 1'b1;
        RDY_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
        default:    m_tready <= pat_cnt[1];
      endcase
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_words
    res_t seen;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.scl_level  = m_tdata[0];
      seen.sda_level  = m_tdata[1];
      seen.busy_res   = m_tdata[2];
      seen.byte_valid = m_tdata[3];
      seen.read_byte  = m_tdata[11:4];
      seen.done_res   = m_tdata[12];
      seen.status     = m_tdata[15:13];
      seen.last_byte  = m_tlast;
      if (bus_words_due.size() == 0) begin
        report("word with nothing expected, data", int'(m_tdata), 0);
      end else begin
        want = bus_words_due.pop_front();
        if (seen.scl_level !== want.scl_level)
          report("scl_level", seen.scl_level, want.scl_level);
        if (seen.sda_level !== want.sda_level)
          report("sda_level", seen.sda_level, want.sda_level);
        if (seen.busy_res !== want.busy_res)
          report("busy_res", seen.busy_res, want.busy_res);
        if (seen.byte_valid !== want.byte_valid)
          report("byte_valid", seen.byte_valid, want.byte_valid);
        if (seen.read_byte !== want.read_byte)
          report("read_byte", seen.read_byte, want.read_byte);
        if (seen.last_byte !== want.last_byte)
          report("last_byte", seen.last_byte, want.last_byte);
        if (seen.done_res !== want.done_res)
          report("done_res", seen.done_res, want.done_res);
        if (seen.status !== want.status)
          report("status", seen.status, want.status);
      end
      words_checked++;
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out with %0d words still expected", bus_words_due.size());
      $display("i2c_register_access_master_core: mismatch");
      $finish;
    end
  end

endmodule
